[src/rap_pkg.sv]
`timescale 1ns / 1ps

package rap_pkg;

   localparam int PayloadWidth  = 8;
   localparam int TimeWidth     = 16;
   localparam int BwWidth       = 10;
   localparam int SfWidth       = 4;
   localparam int PreWidth      = 16;
   localparam int CrWidth       = 3;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   localparam int PayNumWidth   = 14;
   localparam int BlockWidth    = 10;
   localparam int RecipShift    = 14;
   localparam int RecipWidth    = 15;
   localparam int ProdWidth     = BlockWidth + RecipWidth;
   localparam int SymWidth      = 13;
   localparam int QuarterWidth  = 19;
   localparam int DenWidth      = BwWidth + 2;
   localparam int NumWidth      = 35;

   localparam int FrontStages   = 5;
   localparam int DivStages     = 8;
   localparam int DivSteps      = TimeWidth / DivStages;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BANDWIDTH_KHZ     = 3'd0,
      CSR_SPREAD_FACTOR     = 3'd1,
      CSR_PREAMBLE_SYMBOLS  = 3'd2,
      CSR_CRC_ENABLE        = 3'd3,
      CSR_IMPLICIT_HEADER   = 3'd4,
      CSR_CODING_RATE       = 3'd5,
      CSR_LOW_RATE_OPTIMIZE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [BwWidth-1:0]  bandwidth_khz;
      logic [SfWidth-1:0]  spread_factor;
      logic [PreWidth-1:0] preamble_symbols;
      logic                crc_enable;
      logic                implicit_header;
      logic [CrWidth-1:0]  coding_rate;
      logic                low_rate_optimize;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      bandwidth_khz:     10'd500,
      spread_factor:     4'd12,
      preamble_symbols:  16'd8,
      crc_enable:        1'b0,
      implicit_header:   1'b0,
      coding_rate:       3'd4,
      low_rate_optimize: 1'b0
   };

   typedef struct packed {
      logic [NumWidth-1:0] num;
      logic                sat;
   } div_item_type;

   // Symbol divisor spread_factor - 2 * low_rate_optimize, held at one or more.
   function automatic logic [SfWidth-1:0] sym_divisor(input logic [SfWidth-1:0] sf,
                                                      input logic lro);
      logic signed [SfWidth+1:0] d;
      d = $signed({2'b00, sf}) - $signed({4'b0000, lro, 1'b0});
      if (d < 1) begin
         return SfWidth'(1);
      end
      return d[SfWidth-1:0];
   endfunction

   // Rounded-up reciprocal 2^14 / d; exact quotients for dividends up to 1023.
   function automatic logic [RecipWidth-1:0] recip(input logic [SfWidth-1:0] d);
      case (d)
         4'd1:    return 15'd16384;
         4'd2:    return 15'd8192;
         4'd3:    return 15'd5462;
         4'd4:    return 15'd4096;
         4'd5:    return 15'd3277;
         4'd6:    return 15'd2731;
         4'd7:    return 15'd2341;
         4'd8:    return 15'd2048;
         4'd9:    return 15'd1821;
         4'd10:   return 15'd1639;
         4'd11:   return 15'd1490;
         4'd12:   return 15'd1366;
         4'd13:   return 15'd1261;
         4'd14:   return 15'd1171;
         4'd15:   return 15'd1093;
         default: return 15'd16384;
      endcase
   endfunction

endpackage

[src/radio_packet_airtime.sv]
// Throughput: one request per cycle while rsp_stall is low; a 5-stage symbol-count
// pipeline feeds a 9-stage divider, a range check followed by eight stages of two
// quotient bits. A stall on rsp_stall holds each full stage with no empty stage ahead;
// it reaches req_stall combinationally, in the same cycle, once every stage is full.
// Reset clears all pipeline valid bits and loads the default modem settings.
`timescale 1ns / 1ps

module radio_packet_airtime (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rap_pkg::PayloadWidth-1:0]    req_payload_bytes,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rap_pkg::TimeWidth-1:0]       rsp_air_time_ms,
   output logic                                rsp_saturated,
   input  logic                                csr_write_en,
   input  logic [rap_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [rap_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import rap_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         mid_valid;
   logic         mid_stall;
   div_item_type mid_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_BANDWIDTH_KHZ:     cfg_in.bandwidth_khz     = csr_wdata[BwWidth-1:0];
            CSR_SPREAD_FACTOR:     cfg_in.spread_factor     = csr_wdata[SfWidth-1:0];
            CSR_PREAMBLE_SYMBOLS:  cfg_in.preamble_symbols  = csr_wdata[PreWidth-1:0];
            CSR_CRC_ENABLE:        cfg_in.crc_enable        = csr_wdata[0];
            CSR_IMPLICIT_HEADER:   cfg_in.implicit_header   = csr_wdata[0];
            CSR_CODING_RATE:       cfg_in.coding_rate       = csr_wdata[CrWidth-1:0];
            CSR_LOW_RATE_OPTIMIZE: cfg_in.low_rate_optimize = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rap_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (req_valid),
      .in_stall         (req_stall),
      .in_payload_bytes (req_payload_bytes),
      .out_valid        (mid_valid),
      .out_stall        (mid_stall),
      .out_item         (mid_item)
   );

   rap_div u_div (
      .clock           (clock),
      .reset           (reset),
      .bandwidth_khz   (cfg_ff.bandwidth_khz),
      .in_valid        (mid_valid),
      .in_stall        (mid_stall),
      .in_item         (mid_item),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .out_air_time_ms (rsp_air_time_ms),
      .out_saturated   (rsp_saturated)
   );

endmodule

[src/rap_front.sv]
`timescale 1ns / 1ps

module rap_front (
   input  logic                              clock,
   input  logic                              reset,
   input  rap_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   output logic                              in_stall,
   input  logic [rap_pkg::PayloadWidth-1:0]  in_payload_bytes,
   output logic                              out_valid,
   input  logic                              out_stall,
   output rap_pkg::div_item_type             out_item
);
   import rap_pkg::*;

   logic [FrontStages-1:0] vld_ff;
   logic [FrontStages-1:0] vld_in;
   logic [FrontStages:0]   free;

   logic signed [PayNumWidth-1:0] pay_num;
   logic [PayNumWidth-1:0]        pay_round;
   logic [SfWidth-1:0]            divisor;

   logic [BlockWidth-1:0]   dividend_ff, dividend_in;
   logic                    pos1_ff, pos1_in;
   logic [ProdWidth-1:0]    prod_ff, prod_in;
   logic                    pos2_ff, pos2_in;
   logic [BlockWidth-1:0]   blocks;
   logic [SymWidth-1:0]     syms_ff, syms_in;
   logic [QuarterWidth-1:0] quarters_ff, quarters_in;
   div_item_type            item_ff, item_in;
   logic [DenWidth-1:0]     den;
   logic [NumWidth-1:0]     shifted;

   always_comb begin
      free[FrontStages] = !out_stall;
      for (int s = FrontStages - 1; s >= 0; s--) begin
         free[s] = !vld_ff[s] || free[s+1];
      end
      vld_in = {vld_ff[FrontStages-2:0], in_valid};
   end

   assign in_stall  = !free[0];
   assign out_valid = vld_ff[FrontStages-1];
   assign out_item  = item_ff;

   assign divisor = sym_divisor(cfg.spread_factor, cfg.low_rate_optimize);

   always_comb begin
      pay_num = $signed({3'b000, in_payload_bytes, 3'b000})
              - $signed({8'b0, cfg.spread_factor, 2'b00})
              + 14'sd28
              + (cfg.crc_enable ? 14'sd16 : 14'sd0)
              - (cfg.implicit_header ? 14'sd20 : 14'sd0);
      pay_round   = PayNumWidth'(pay_num + 14'sd3);
      pos1_in     = pay_num > 14'sd0;
      dividend_in = pay_round[BlockWidth+1:2] + BlockWidth'(divisor) - BlockWidth'(1);
   end

   always_comb begin
      prod_in = ProdWidth'(dividend_ff) * ProdWidth'(recip(divisor));
      pos2_in = pos1_ff;
   end

   always_comb begin
      blocks  = pos2_ff ? prod_ff[RecipShift+BlockWidth-1:RecipShift] : '0;
      syms_in = SymWidth'(14'd8 + 14'(blocks) * 14'({1'b0, cfg.coding_rate} + 4'd4));
   end

   assign quarters_in = QuarterWidth'({cfg.preamble_symbols, 2'b00})
                      + QuarterWidth'(17) + QuarterWidth'({syms_ff, 2'b00});

   always_comb begin
      den          = {cfg.bandwidth_khz, 2'b00};
      shifted      = NumWidth'(quarters_ff) << cfg.spread_factor;
      item_in.num  = shifted + NumWidth'(den) - NumWidth'(1);
      item_in.sat  = cfg.bandwidth_khz == '0;
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < FrontStages; s++) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (free[s]) begin
            vld_ff[s] <= vld_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (free[0]) begin
         dividend_ff <= dividend_in;
         pos1_ff     <= pos1_in;
      end
      if (free[1]) begin
         prod_ff <= prod_in;
         pos2_ff <= pos2_in;
      end
      if (free[2]) begin
         syms_ff <= syms_in;
      end
      if (free[3]) begin
         quarters_ff <= quarters_in;
      end
      if (free[4]) begin
         item_ff <= item_in;
      end
   end

endmodule

[src/rap_div.sv]
`timescale 1ns / 1ps

module rap_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rap_pkg::BwWidth-1:0]    bandwidth_khz,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  rap_pkg::div_item_type          in_item,
   output logic                           out_valid,
   input  logic                           out_stall,
   output logic [rap_pkg::TimeWidth-1:0]  out_air_time_ms,
   output logic                           out_saturated
);
   import rap_pkg::*;

   logic [DivStages:0]   vld_ff;
   logic [DivStages:0]   vld_in;
   logic [DivStages+1:0] free;

   logic [NumWidth-1:0]  rem_ff [0:DivStages];
   logic [NumWidth-1:0]  rem_in [0:DivStages];
   logic [TimeWidth-1:0] quo_ff [0:DivStages];
   logic [TimeWidth-1:0] quo_in [0:DivStages];
   logic [DivStages:0]   sat_ff;
   logic [DivStages:0]   sat_in;
   logic [NumWidth-1:0]  den;

   assign den = NumWidth'({bandwidth_khz, 2'b00});

   always_comb begin
      free[DivStages+1] = !out_stall;
      for (int s = DivStages; s >= 0; s--) begin
         free[s] = !vld_ff[s] || free[s+1];
      end
      vld_in = {vld_ff[DivStages-1:0], in_valid};
   end

   assign in_stall        = !free[0];
   assign out_valid       = vld_ff[DivStages];
   assign out_saturated   = sat_ff[DivStages];
   assign out_air_time_ms = sat_ff[DivStages] ? '1 : quo_ff[DivStages];

   // The quotient is known to fit once the dividend is below den * 2^16.
   always_comb begin
      logic [NumWidth-1:0]  r;
      logic [TimeWidth-1:0] q;
      logic [NumWidth-1:0]  sub;
      rem_in[0] = in_item.num;
      quo_in[0] = '0;
      sat_in[0] = in_item.sat || (in_item.num >= (den << TimeWidth));
      for (int s = 1; s <= DivStages; s++) begin
         r = rem_ff[s-1];
         q = quo_ff[s-1];
         for (int j = 0; j < DivSteps; j++) begin
            sub = den << (TimeWidth - 1 - (s - 1) * DivSteps - j);
            if (r >= sub) begin
               r = r - sub;
               q = {q[TimeWidth-2:0], 1'b1};
            end else begin
               q = {q[TimeWidth-2:0], 1'b0};
            end
         end
         rem_in[s] = r;
         quo_in[s] = q;
         sat_in[s] = sat_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= DivStages; s++) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (free[s]) begin
            vld_ff[s] <= vld_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= DivStages; s++) begin
         if (free[s]) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            sat_ff[s] <= sat_in[s];
         end
      end
   end

endmodule

[test/radio_packet_airtime_test.sv]
`timescale 1ns / 1ps

module radio_packet_airtime_test;
   import rap_pkg::*;

   localparam int ClockHalf = 6;
   localparam int ResetCycles = 11;
   localparam int RandomItems = 1750;
   localparam int TailCycles = 24;
   localparam int ReportLimit = 10;
   localparam logic [CsrIndexWidth-1:0] CsrUnused = 3'd7;

   typedef struct packed {
      logic [TimeWidth-1:0] air_time_ms;
      logic                 saturated;
   } airtime_type;

   class airtime_scoreboard;
      cfg_type     modem;
      airtime_type pending_airtimes[$];
      int          results_checked;
      int          saturated_seen;
      int          mismatches;

      function new();
         modem = CfgReset;
      endfunction

      function void set_register(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] value);
         case (idx)
            CSR_BANDWIDTH_KHZ:     modem.bandwidth_khz = value[BwWidth-1:0];
            CSR_SPREAD_FACTOR:     modem.spread_factor = value[SfWidth-1:0];
            CSR_PREAMBLE_SYMBOLS:  modem.preamble_symbols = value[PreWidth-1:0];
            CSR_CRC_ENABLE:        modem.crc_enable = value[0];
            CSR_IMPLICIT_HEADER:   modem.implicit_header = value[0];
            CSR_CODING_RATE:       modem.coding_rate = value[CrWidth-1:0];
            CSR_LOW_RATE_OPTIMIZE: modem.low_rate_optimize = value[0];
            default: ;
         endcase
      endfunction

      // Time on air counted in quarter symbols, with a ceiling on the payload blocks and a final ceiling.
      function airtime_type predict_airtime(logic [PayloadWidth-1:0] len);
         longint      bits_num;
         longint      sym_div;
         longint      symbols;
         longint      quarters;
         longint      scaled;
         longint      den;
         longint      ms;
         airtime_type r;
         r.air_time_ms = '1;
         r.saturated = 1'b1;
         if (modem.bandwidth_khz == 0) begin
            return r;
         end
         bits_num = 8 * longint'(len) - 4 * longint'(modem.spread_factor) + 28
                  + 16 * longint'(modem.crc_enable) - 20 * longint'(modem.implicit_header);
         sym_div = longint'(modem.spread_factor) - 2 * longint'(modem.low_rate_optimize);
         if (sym_div < 1) begin
            sym_div = 1;
         end
         sym_div = 4 * sym_div;
         symbols = 8;
         if (bits_num > 0) begin
            symbols = 8 + ((bits_num + sym_div - 1) / sym_div) * (longint'(modem.coding_rate) + 4);
         end
         quarters = 4 * longint'(modem.preamble_symbols) + 17 + 4 * symbols;
         scaled = quarters << modem.spread_factor;
         den = 4 * longint'(modem.bandwidth_khz);
         ms = (scaled + den - 1) / den;
         if (ms <= 65535) begin
            r.air_time_ms = ms[TimeWidth-1:0];
            r.saturated = 1'b0;
         end
         return r;
      endfunction

      function void note_request(logic [PayloadWidth-1:0] len);
         pending_airtimes.push_back(predict_airtime(len));
      endfunction

      function void check_result(logic [TimeWidth-1:0] air_time_ms, logic saturated);
         airtime_type want;
         results_checked++;
         if (pending_airtimes.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("Unexpected result: air_time_ms %0d saturated %0b", air_time_ms,
                        saturated);
            end
            return;
         end
         want = pending_airtimes.pop_front();
         if (want.saturated) begin
            saturated_seen++;
         end
         if (air_time_ms !== want.air_time_ms || saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("Mismatch at %0t: air_time_ms %0d (expected %0d),", $realtime,
                        air_time_ms, want.air_time_ms);
               $display("   saturated %0b (expected %0b)", saturated, want.saturated);
            end
         end
      endfunction

      function int pending();
         return pending_airtimes.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [PayloadWidth-1:0]  req_payload_bytes = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [TimeWidth-1:0]     rsp_air_time_ms;
   logic                     rsp_saturated;
   logic                     csr_write_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   bit                 steady = 1'b0;
   int                 settings_used = 0;
   airtime_scoreboard  book = new();

   radio_packet_airtime uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_payload_bytes (req_payload_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_air_time_ms   (rsp_air_time_ms),
      .rsp_saturated     (rsp_saturated),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d results outstanding.", book.pending());
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         book.check_result(rsp_air_time_ms, rsp_saturated);
      end
      rsp_stall <= !steady && ($urandom_range(99) < 25);
   end

   task automatic offer_length(input logic [PayloadWidth-1:0] len);
      if (!steady) begin
         while ($urandom_range(99) < 25) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_payload_bytes <= len;
      do @(posedge clock); while (req_stall);
      book.note_request(len);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] idx,
                                 input logic [CsrDataWidth-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      book.set_register(idx, value);
   endtask

   // Bits above a register's width are filled with noise; the block drops them.
   function automatic logic [CsrDataWidth-1:0] with_noise(logic [CsrDataWidth-1:0] field,
                                                         int width);
      return (CsrDataWidth'($urandom) << width) | field;
   endfunction

   task automatic apply_settings(input cfg_type c);
      write_register(CSR_BANDWIDTH_KHZ, with_noise(CsrDataWidth'(c.bandwidth_khz), BwWidth));
      write_register(CSR_SPREAD_FACTOR, with_noise(CsrDataWidth'(c.spread_factor), SfWidth));
      write_register(CSR_PREAMBLE_SYMBOLS, c.preamble_symbols);
      write_register(CSR_CRC_ENABLE, with_noise(CsrDataWidth'(c.crc_enable), 1));
      write_register(CSR_IMPLICIT_HEADER, with_noise(CsrDataWidth'(c.implicit_header), 1));
      write_register(CSR_CODING_RATE, with_noise(CsrDataWidth'(c.coding_rate), CrWidth));
      write_register(CSR_LOW_RATE_OPTIMIZE,
                     with_noise(CsrDataWidth'(c.low_rate_optimize), 1));
      write_register(CsrUnused, CsrDataWidth'($urandom));
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic directed_case(input cfg_type c, input logic [PayloadWidth-1:0] first,
                                input logic [PayloadWidth-1:0] second);
      drain_results();
      apply_settings(c);
      offer_length(first);
      offer_length(second);
   endtask

   function automatic cfg_type random_settings();
      cfg_type c;
      case ($urandom_range(19))
         0:         c.bandwidth_khz = '0;
         1:         c.bandwidth_khz = '1;
         2, 3, 4:   c.bandwidth_khz = 10'd125;
         5, 6, 7:   c.bandwidth_khz = 10'd250;
         8, 9, 10:  c.bandwidth_khz = 10'd500;
         default:   c.bandwidth_khz = BwWidth'($urandom_range(1, 1023));
      endcase
      c.spread_factor = ($urandom_range(9) < 8) ? SfWidth'($urandom_range(6, 12))
                                                : SfWidth'($urandom_range(15));
      case ($urandom_range(9))
         0:       c.preamble_symbols = '1;
         1:       c.preamble_symbols = PreWidth'($urandom_range(65535));
         default: c.preamble_symbols = PreWidth'($urandom_range(0, 16));
      endcase
      c.crc_enable = 1'($urandom_range(1));
      c.implicit_header = 1'($urandom_range(1));
      c.coding_rate = ($urandom_range(9) < 8) ? CrWidth'($urandom_range(1, 4))
                                              : CrWidth'($urandom_range(7));
      c.low_rate_optimize = 1'($urandom_range(1));
      return c;
   endfunction

   initial begin : stimulus
      cfg_type                 c;
      int                      random_sent;
      int                      phase;
      int                      n;
      logic [PayloadWidth-1:0] len;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // The power-on settings are used as they come out of reset.
      offer_length(8'd0);
      offer_length(8'd255);
      offer_length(8'd1);
      offer_length(8'd128);
      offer_length(8'd85);
      offer_length(8'd170);

      // Zero bandwidth reports an unbounded time.
      c = CfgReset;
      c.bandwidth_khz = '0;
      directed_case(c, 8'd0, 8'd255);

      // Bandwidth above 1000, spreading factor 0 with a degenerate divisor, rate 0.
      c = CfgReset;
      c.bandwidth_khz = '1;
      c.spread_factor = '0;
      c.coding_rate = '0;
      directed_case(c, 8'd0, 8'd255);

      // Low rate optimization pushes the raw symbol divisor to zero, where it is held at one.
      c = CfgReset;
      c.bandwidth_khz = 10'd1;
      c.spread_factor = 4'd2;
      c.low_rate_optimize = 1'b1;
      c.coding_rate = '1;
      c.preamble_symbols = '0;
      c.crc_enable = 1'b1;
      directed_case(c, 8'd0, 8'd255);

      // Longest packets saturate.
      c = CfgReset;
      c.bandwidth_khz = 10'd1;
      c.spread_factor = '1;
      c.preamble_symbols = '1;
      c.coding_rate = 3'd5;
      directed_case(c, 8'd0, 8'd255);

      // Short payloads in implicit header mode give a non-positive numerator.
      c = CfgReset;
      c.bandwidth_khz = 10'd125;
      c.implicit_header = 1'b1;
      c.coding_rate = 3'd6;
      c.preamble_symbols = '0;
      c.low_rate_optimize = 1'b1;
      directed_case(c, 8'd0, 8'd5);
      offer_length(8'd6);
      offer_length(8'd255);

      c = CfgReset;
      c.spread_factor = 4'd13;
      c.preamble_symbols = '1;
      c.coding_rate = 3'd3;
      c.low_rate_optimize = 1'b1;
      directed_case(c, 8'd0, 8'd255);

      random_sent = 0;
      phase = 0;
      while (random_sent < RandomItems) begin
         drain_results();
         apply_settings(random_settings());
         steady = (phase == 3);
         n = $urandom_range(100, 150);
         if (n > RandomItems - random_sent) begin
            n = RandomItems - random_sent;
         end
         for (int i = 0; i < n; i++) begin
            if (phase == 5 && i == n / 2) begin
               drain_results();
            end
            if ($urandom_range(9) == 0) begin
               len = $urandom_range(1) ? '1 : '0;
            end else begin
               len = PayloadWidth'($urandom_range(255));
            end
            offer_length(len);
         end
         random_sent += n;
         phase++;
      end
      steady = 1'b0;

      drain_results();
      repeat (TailCycles) @(posedge clock);
      $display("Checked %0d airtime results over %0d modem settings.", book.results_checked,
               settings_used);
      $display("%0d of them saturated; %0d mismatches counted.", book.saturated_seen,
               book.mismatches);
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
src/rap_pkg.sv
src/rap_front.sv
src/rap_div.sv
src/radio_packet_airtime.sv
test/radio_packet_airtime_test.sv
